### sv/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Types and constants shared by the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int OPW   = 16;
    localparam int MW    = 2 * OPW;
    localparam int CW    = $clog2(MW + 1);
    localparam int NUM_W = 33;
    localparam int DEN_W = 31;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_EQ  = 3'd4;

    typedef struct packed {
        logic [2:0]            op;
        logic signed [OPW-1:0] a_num;
        logic signed [OPW-1:0] a_den;
        logic signed [OPW-1:0] b_num;
        logic signed [OPW-1:0] b_den;
    } t_in;

    typedef struct packed {
        logic signed [NUM_W-1:0] res_num;
        logic [DEN_W-1:0]        res_den;
        logic                    is_equal;
        logic                    den_forced;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_FORM,
        S_GCD,
        S_GSH,
        S_DIV,
        S_DONE
    } t_state;

endpackage

### sv/rau_mul.sv
// ----------------------------------------------------------------------------
// rau_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module rau_mul (
    input  logic                              i_clk,
    input  logic signed [rau_pkg::OPW-1:0]    i_a,
    input  logic signed [rau_pkg::OPW-1:0]    i_b,
    output logic signed [2*rau_pkg::OPW-1:0]  o_p
);
    import rau_pkg::*;

    logic signed [2*OPW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

### sv/rational_arith_unit_core.sv
// ----------------------------------------------------------------------------
// rational_arith_unit_core
// Rational ALU: add, subtract, multiply, divide, equality; GCD reduction.
//
//   channel   dir   payload      handshake
//   input     in    i_data t_in  i_valid / o_stall
//   output    out   o_data t_out o_valid / i_stall
//
// An item goes through the multiplier pass, a binary GCD of one step per
// cycle, a shift back by the common power of two, and two bit-serial
// divisions that divide numerator and denominator by the GCD.
// Equality and unused op codes finish after the multiplier pass or at once.
// Reset is synchronous and clears the sequencer and output valid.
// o_stall is high while an item is in work; a stalled result beat holds.
// ----------------------------------------------------------------------------
module rational_arith_unit_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  rau_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output rau_pkg::t_out o_data
);
    import rau_pkg::*;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [2:0] r_op, n_op;
    logic signed [OPW-1:0] r_an, n_an, r_ad, n_ad, r_bn, n_bn, r_bd, n_bd;
    logic r_forced, n_forced;
    logic signed [MW-1:0] r_p [4];
    logic signed [MW-1:0] n_p [4];
    logic r_neg, n_neg, r_eq, n_eq, r_pass, n_pass;
    logic [MW-1:0] r_un, n_un, r_ud, n_ud, r_ga, n_ga, r_gb, n_gb, r_quo, n_quo;
    logic [MW:0] r_rem, n_rem;
    logic r_ovalid, n_ovalid;
    t_out r_out, n_out;

    logic signed [OPW-1:0] mul_a, mul_b;
    logic signed [MW-1:0]  mul_p;
    logic signed [MW:0]    nr, dr, dv;
    logic [MW:0]           rem_sh;
    logic                  ge;
    logic [63:0]           ext_un, ext_sv;

    rau_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    begin mul_a = r_an; mul_b = r_bd; end
            2'd1:    begin mul_a = r_ad; mul_b = r_bn; end
            2'd2:    begin mul_a = r_ad; mul_b = r_bd; end
            default: begin mul_a = r_an; mul_b = r_bn; end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_op = r_op;
        n_an = r_an; n_ad = r_ad; n_bn = r_bn; n_bd = r_bd;
        n_forced = r_forced;
        n_p = r_p;
        n_neg = r_neg; n_eq = r_eq; n_pass = r_pass;
        n_un = r_un; n_ud = r_ud; n_ga = r_ga; n_gb = r_gb;
        n_quo = r_quo; n_rem = r_rem;
        n_ovalid = r_ovalid;
        n_out = r_out;
        nr = '0; dr = '0; dv = '0;
        rem_sh = {r_rem[MW-1:0], r_quo[MW-1]};
        ge = (rem_sh >= {1'b0, r_gb});
        ext_un = 64'(r_un);
        ext_sv = r_neg ? (64'd0 - ext_un) : ext_un;

        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op = i_data.op;
                    n_an = i_data.a_num;
                    n_bn = i_data.b_num;
                    n_ad = (i_data.a_den == '0) ? OPW'(1) : i_data.a_den;
                    n_bd = (i_data.b_den == '0) ? OPW'(1) : i_data.b_den;
                    n_forced = (i_data.a_den == '0) || (i_data.b_den == '0);
                    n_cnt = '0;
                    n_state = (i_data.op > OP_EQ) ? S_DONE : S_MUL;
                end
            end
            S_MUL: begin
                if (r_cnt != '0) begin
                    n_p[2'(r_cnt - CW'(1))] = mul_p;
                end
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(4)) begin
                    n_state = S_FORM;
                end
            end
            S_FORM: begin
                case (r_op)
                    OP_ADD: begin
                        nr = (MW+1)'(r_p[0]) + (MW+1)'(r_p[1]);
                        dr = (MW+1)'(r_p[2]);
                    end
                    OP_SUB: begin
                        nr = (MW+1)'(r_p[0]) - (MW+1)'(r_p[1]);
                        dr = (MW+1)'(r_p[2]);
                    end
                    OP_MUL: begin
                        nr = (MW+1)'(r_p[3]);
                        dr = (MW+1)'(r_p[2]);
                    end
                    default: begin
                        nr = (MW+1)'(r_p[0]);
                        dr = (MW+1)'(r_p[1]);
                    end
                endcase
                dv = (dr == '0) ? (MW+1)'(1) : dr;
                n_eq = (r_p[0] == r_p[1]);
                if (r_op == OP_EQ) begin
                    n_state = S_DONE;
                end else begin
                    if (dr == '0) begin
                        n_forced = 1'b1;
                    end
                    n_neg = nr[MW] ^ dv[MW];
                    n_un = nr[MW] ? MW'(-nr) : MW'(nr);
                    n_ud = dv[MW] ? MW'(-dv) : MW'(dv);
                    n_ga = n_un;
                    n_gb = n_ud;
                    n_cnt = '0;
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                if (r_ga == '0) begin
                    n_state = S_GSH;
                end else if (!r_ga[0] && !r_gb[0]) begin
                    n_ga = r_ga >> 1;
                    n_gb = r_gb >> 1;
                    n_cnt = r_cnt + CW'(1);
                end else if (!r_ga[0]) begin
                    n_ga = r_ga >> 1;
                end else if (!r_gb[0]) begin
                    n_gb = r_gb >> 1;
                end else if (r_ga >= r_gb) begin
                    n_ga = r_ga - r_gb;
                end else begin
                    n_gb = r_gb - r_ga;
                end
            end
            S_GSH: begin
                if (r_cnt == '0) begin
                    n_rem = '0;
                    n_quo = r_un;
                    n_pass = 1'b0;
                    n_state = S_DIV;
                end else begin
                    n_gb = r_gb << 1;
                    n_cnt = r_cnt - CW'(1);
                end
            end
            S_DIV: begin
                n_rem = ge ? (rem_sh - {1'b0, r_gb}) : rem_sh;
                n_quo = {r_quo[MW-2:0], ge};
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(MW - 1)) begin
                    n_cnt = '0;
                    if (!r_pass) begin
                        n_un = {r_quo[MW-2:0], ge};
                        n_quo = r_ud;
                        n_rem = '0;
                        n_pass = 1'b1;
                    end else begin
                        n_ud = {r_quo[MW-2:0], ge};
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_out.res_num = '0;
                    n_out.res_den = DEN_W'(1);
                    n_out.is_equal = 1'b0;
                    n_out.den_forced = 1'b0;
                    if (r_op == OP_EQ) begin
                        n_out.is_equal = r_eq;
                        n_out.den_forced = r_forced;
                    end else if (r_op <= OP_DIV) begin
                        n_out.res_num = ext_sv[NUM_W-1:0];
                        n_out.res_den = DEN_W'(r_ud);
                        n_out.den_forced = r_forced;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_pass <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_pass <= n_pass;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
        r_an <= n_an;
        r_ad <= n_ad;
        r_bn <= n_bn;
        r_bd <= n_bd;
        r_forced <= n_forced;
        r_p <= n_p;
        r_neg <= n_neg;
        r_eq <= n_eq;
        r_un <= n_un;
        r_ud <= n_ud;
        r_ga <= n_ga;
        r_gb <= n_gb;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_out <= n_out;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

endmodule

### sv/rau_checker.sv
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks for the rational arithmetic unit.
// ----------------------------------------------------------------------------
module rau_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_stall,
    input rau_pkg::t_in  i_data,
    input logic          o_valid,
    input logic          i_stall,
    input rau_pkg::t_out o_data
);
    import rau_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result beat changed while stalled");

    a_den_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.res_den != '0)
        else $error("zero result denominator");

    a_eq_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.is_equal |-> o_data.res_num == '0 && o_data.res_den == DEN_W'(1))
        else $error("equal flag with arithmetic result");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken without going busy");

endmodule

bind rational_arith_unit_core rau_checker u_rau_checker (.*);

### tb/tb_rational_arith_unit_core.sv
// ----------------------------------------------------------------------------
// tb_rational_arith_unit_core
// Checks the rational ALU against a predictor that forms the exact raw
// fraction, moves the sign into the numerator and reduces by Euclid's GCD.
// Directed corner beats come first, then random beats with random gaps on
// both the input and the output channel.
// ----------------------------------------------------------------------------
module tb_rational_arith_unit_core;
    timeunit 1ns;
    timeprecision 1ps;

    import rau_pkg::*;

    localparam int N_RANDOM    = 1080;
    localparam int CYCLE_LIMIT = 4000000;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in  i_data;
    logic o_valid;
    logic i_stall;
    t_out o_data;

    t_in  pending_q[$];
    t_out fraction_q[$];
    int   n_errors;
    int   n_results;
    int   n_sent;
    int   gap_left;
    int   stall_left;
    int   cycle_cnt;
    bit   stim_done;
    bit   hold_off;

    rational_arith_unit_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic t_out reduce_fraction(t_in it);
        t_out            r;
        longint          an, ad, bn, bd, n, d;
        longint unsigned un, ud, g;
        bit              neg;
        r            = '0;
        r.res_den    = DEN_W'(1);
        an = it.a_num;
        ad = it.a_den;
        bn = it.b_num;
        bd = it.b_den;
        if (it.op > OP_EQ) return r;
        if (ad == 0) begin
            ad = 1;
            r.den_forced = 1'b1;
        end
        if (bd == 0) begin
            bd = 1;
            r.den_forced = 1'b1;
        end
        if (it.op == OP_EQ) begin
            r.is_equal = (an * bd == bn * ad);
            return r;
        end
        case (it.op)
            OP_ADD: begin
                n = an * bd + ad * bn;
                d = ad * bd;
            end
            OP_SUB: begin
                n = an * bd - ad * bn;
                d = ad * bd;
            end
            OP_MUL: begin
                n = an * bn;
                d = ad * bd;
            end
            default: begin
                n = an * bd;
                d = ad * bn;
            end
        endcase
        if (d == 0) begin
            d = 1;
            r.den_forced = 1'b1;
        end
        if (d < 0) begin
            n = -n;
            d = -d;
        end
        neg = n < 0;
        un  = neg ? -n : n;
        ud  = d;
        g   = euclid_gcd(un, ud);
        if (g == 0) g = 1;
        un = un / g;
        ud = ud / g;
        if (neg) un = -un;
        r.res_num = un[NUM_W-1:0];
        r.res_den = ud[DEN_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_cnt);
        n_errors++;
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 15) == 0) return $urandom_range(10, 300);
        return $urandom_range(0, 4);
    endfunction

    function automatic logic [OPW-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 16'sh7fff;
            2: return 16'sh8000;
            3: return $urandom_range(0, 1) ? 16'sh0001 : 16'shffff;
            4: return OPW'($urandom_range(0, 12) - 6);
            5: return OPW'($urandom_range(0, 64) * ($urandom_range(0, 1) ? 4 : 6));
            default: return OPW'($urandom);
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left <= 0;
        end else if (i_valid && !o_stall) begin
            n_sent <= n_sent + 1;
            fraction_q.push_back(reduce_fraction(i_data));
            if (pending_q.size() > 0 && !hold_off && pick_gap() == 0) begin
                i_data <= pending_q.pop_front();
            end else begin
                i_valid  <= 1'b0;
                gap_left <= pick_gap();
            end
        end else if (!i_valid) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (pending_q.size() > 0 && !hold_off) begin
                i_valid <= 1'b1;
                i_data  <= pending_q.pop_front();
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                n_results <= n_results + 1;
                if (fraction_q.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end else begin
                    t_out w;
                    w = fraction_q.pop_front();
                    if (o_data.res_num !== w.res_num)
                        report_mismatch("res_num", o_data.res_num, w.res_num);
                    if (o_data.res_den !== w.res_den)
                        report_mismatch("res_den", o_data.res_den, w.res_den);
                    if (o_data.is_equal !== w.is_equal)
                        report_mismatch("is_equal", o_data.is_equal, w.is_equal);
                    if (o_data.den_forced !== w.den_forced)
                        report_mismatch("den_forced", o_data.den_forced, w.den_forced);
                end
            end
            if (stall_left > 0) begin
                i_stall    <= 1'b1;
                stall_left <= stall_left - 1;
            end else if ($urandom_range(0, 3) == 0) begin
                i_stall    <= 1'b1;
                stall_left <= pick_gap();
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        t_in it;
        int  waited;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_stall    = 1'b0;
        i_data     = '0;
        n_errors   = 0;
        n_results  = 0;
        n_sent     = 0;
        cycle_cnt  = 0;
        stim_done  = 1'b0;
        hold_off   = 1'b0;
        gap_left   = 0;
        stall_left = 0;

        for (int op = 0; op < 8; op++) begin
            pending_q.push_back('{op[2:0], 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff});
            pending_q.push_back('{op[2:0], 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
        end
        pending_q.push_back('{OP_ADD, 16'sd3, 16'sd0, 16'sd2, 16'sd0});
        pending_q.push_back('{OP_DIV, 16'sd5, 16'sd7, 16'sd0, 16'sd3});
        pending_q.push_back('{OP_DIV, -16'sd5, 16'sd7, 16'sd0, -16'sd3});
        pending_q.push_back('{OP_MUL, 16'sd0, -16'sd9, 16'sd4, 16'sd6});
        pending_q.push_back('{OP_SUB, 16'sd2, 16'sd4, 16'sd1, 16'sd2});
        pending_q.push_back('{OP_EQ, 16'sd2, 16'sd4, -16'sd1, -16'sd2});
        pending_q.push_back('{OP_EQ, 16'sd2, 16'sd0, 16'sd4, 16'sd2});
        pending_q.push_back('{OP_ADD, -16'sd1, -16'sd3, 16'sd1, 16'sd6});

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_RANDOM; k++) begin
            it.op    = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                                    : 3'($urandom_range(0, 4));
            it.a_num = pick_operand();
            it.a_den = pick_operand();
            it.b_num = pick_operand();
            it.b_den = pick_operand();
            pending_q.push_back(it);
            if (k == N_RANDOM / 2) begin
                while (pending_q.size() > 0 || i_valid) @(posedge i_clk);
                hold_off = 1'b1;
                while (fraction_q.size() > 0) @(posedge i_clk);
                hold_off = 1'b0;
            end
        end
        while (pending_q.size() > 0 || i_valid) @(posedge i_clk);
        waited = 0;
        while (fraction_q.size() > 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (300) @(posedge i_clk);
        stim_done = 1'b1;
    end

    always @(posedge i_clk) begin
        if (stim_done) begin
            $display("covered %0d beats in, %0d results out, all ops and corner operands",
                     n_sent, n_results);
            if (n_errors == 0 && fraction_q.size() == 0) begin
                $display("tb: success");
            end else begin
                $display("tb: failure");
            end
            $finish;
        end else if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout at cycle %0d", cycle_cnt);
            $display("tb: failure");
            $finish;
        end
    end
endmodule
